/* rtl/sld_pkg.sv */
// Shared types and constants for the start/length/XOR frame receiver.
package sld_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] START_VALUE_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET     = 8'd64;

    // Configuration register indexes.
    localparam logic CFG_START_VALUE = 1'b0;
    localparam logic CFG_MAX_LEN     = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_BADLEN = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] frame_len;
        logic              last_flag;
    } result_t;

endpackage

/* rtl/sld_frame_fsm.sv */
// Frame state machine: phase, length count and running XOR, one byte per step.
module sld_frame_fsm
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [sld_pkg::BYTE_W-1:0]   byte_in,
    input  logic [sld_pkg::BYTE_W-1:0]   start_value,
    input  logic [sld_pkg::BYTE_W-1:0]   max_len,
    output sld_pkg::result_t             res
);

    sld_pkg::phase_t             phase_reg;
    sld_pkg::phase_t             phase_next;
    logic [sld_pkg::BYTE_W-1:0]  remaining_reg;
    logic [sld_pkg::BYTE_W-1:0]  remaining_next;
    logic [sld_pkg::BYTE_W-1:0]  xor_reg;
    logic [sld_pkg::BYTE_W-1:0]  xor_next;
    logic [sld_pkg::BYTE_W-1:0]  len_reg;
    logic [sld_pkg::BYTE_W-1:0]  len_next;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        len_next       = len_reg;
        res.valid      = 1'b0;
        res.kind       = sld_pkg::KIND_DATA;
        res.data_byte  = byte_in;
        res.frame_len  = len_reg;
        res.last_flag  = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                sld_pkg::PH_HUNT:
                begin
                    if (byte_in == start_value)
                    begin
                        phase_next = sld_pkg::PH_LEN;
                    end
                end
                sld_pkg::PH_LEN:
                begin
                    len_next = byte_in;
                    xor_next = '0;
                    if (byte_in > max_len)
                    begin
                        phase_next     = sld_pkg::PH_HUNT;
                        remaining_next = '0;
                        res.valid      = 1'b1;
                        res.kind       = sld_pkg::KIND_BADLEN;
                        res.frame_len  = byte_in;
                        res.last_flag  = 1'b1;
                    end
                    else
                    begin
                        remaining_next = byte_in;
                        phase_next     = (byte_in == '0) ? sld_pkg::PH_CHECK
                                                          : sld_pkg::PH_DATA;
                    end
                end
                sld_pkg::PH_DATA:
                begin
                    xor_next       = xor_reg ^ byte_in;
                    remaining_next = remaining_reg - 1'b1;
                    res.valid      = 1'b1;
                    if (remaining_reg == 8'd1)
                    begin
                        phase_next = sld_pkg::PH_CHECK;
                    end
                end
                sld_pkg::PH_CHECK:
                begin
                    res.valid     = 1'b1;
                    res.kind      = (byte_in == xor_reg) ? sld_pkg::KIND_GOOD
                                                         : sld_pkg::KIND_BADSUM;
                    res.last_flag = 1'b1;
                    phase_next    = sld_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = sld_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sld_pkg::PH_HUNT;
            remaining_reg <= '0;
            xor_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            len_reg       <= len_next;
        end
    end

    // The payload phase is only entered with bytes still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sld_pkg::PH_DATA |-> remaining_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // Skipped bytes during the hunt never produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sld_pkg::PH_HUNT |-> !res.valid)
        else $error("result produced while hunting");

    // Only status results close a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.last_flag == (res.kind != sld_pkg::KIND_DATA)))
        else $error("last flag disagrees with result kind");

    // A rejected length sends the machine back to the hunt.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == sld_pkg::KIND_BADLEN |=> phase_reg == sld_pkg::PH_HUNT)
        else $error("no return to hunt after length error");

endmodule

/* rtl/sld_out_reg.sv */
// Result register on the output channel; it holds a beat while the receiver stalls.
module sld_out_reg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  sld_pkg::result_t             res,
    input  logic                         out_stall,
    output logic                         ready,
    output logic                         out_valid,
    output sld_pkg::kind_t               kind,
    output logic [sld_pkg::BYTE_W-1:0]   data_byte,
    output logic [sld_pkg::BYTE_W-1:0]   frame_len,
    output logic                         last_flag
);

    logic                        valid_reg;
    logic                        valid_next;
    sld_pkg::kind_t              kind_reg;
    logic [sld_pkg::BYTE_W-1:0]  data_reg;
    logic [sld_pkg::BYTE_W-1:0]  len_reg;
    logic                        last_reg;

    // The register can take a new result when it is empty or being drained.
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = res.valid;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data_byte;
            len_reg  <= res.frame_len;
            last_reg <= res.last_flag;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign frame_len = len_reg;
    assign last_flag = last_reg;

endmodule

/* rtl/start_length_xor_deframer.sv */
// Top level of the start/length/XOR frame receiver.
//
// Input channel: one received byte per beat on rx_byte (in_valid / in_stall).
// The block hunts for the start byte, takes the length byte, passes every
// payload byte out as a kind 0 beat, and ends the frame with one status beat:
// frame good, checksum mismatch, or length too long. Bytes skipped during the
// hunt, the start byte and an accepted length byte give no output beat.
// Output channel: kind, data_byte, frame_len, last_flag (out_valid / out_stall).
// Each accepted byte goes first into the input register and from there into
// the result register, which presents its result. Throughput is one byte per
// cycle while the receiver does not stall; both registers can advance in the
// same cycle.
// When the receiver stalls, the held result stays put and the input register
// fills; in_stall rises once the input register holds a byte that cannot move.
// Reset clears the frame state to hunting and loads the registers with start
// value 0xAA and maximum length 64. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the next edge and belong only to idle periods.
module start_length_xor_deframer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sld_pkg::BYTE_W-1:0]   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [sld_pkg::BYTE_W-1:0]   data_byte,
    output logic [sld_pkg::BYTE_W-1:0]   frame_len,
    output logic                         last_flag,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [sld_pkg::BYTE_W-1:0]   cfg_data
);

    logic [sld_pkg::BYTE_W-1:0]  start_value_reg;
    logic [sld_pkg::BYTE_W-1:0]  max_len_reg;
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [sld_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        out_ready;
    logic                        advance;
    logic                        in_take;
    sld_pkg::result_t            res;
    sld_pkg::kind_t              kind_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= sld_pkg::START_VALUE_RESET;
            max_len_reg     <= sld_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sld_pkg::CFG_START_VALUE: start_value_reg <= cfg_data;
                sld_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg_data;
                default:                  start_value_reg <= start_value_reg;
            endcase
        end
    end

    // The held byte moves on whenever the result register can take its outcome.
    assign advance  = in_valid_reg && out_ready;
    assign in_stall = in_valid_reg && !out_ready;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else
        begin
            in_valid_next = in_valid_reg && !advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sld_frame_fsm u_fsm
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .byte_in     (in_byte_reg),
        .start_value (start_value_reg),
        .max_len     (max_len_reg),
        .res         (res)
    );

    sld_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .out_stall (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .kind      (kind_out),
        .data_byte (data_byte),
        .frame_len (frame_len),
        .last_flag (last_flag)
    );

    assign kind = kind_out;

endmodule
